// ===== sv/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
package stq_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int ID_W           = 4;
    localparam int FIELD_TIME_W   = 32;
    localparam int RESULT_CAP     = 16;
    localparam int CNT_W          = $clog2(RESULT_CAP);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_ADJUST = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ACTIVE = 2'd1,
        ST_ACTIVE     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PLACE,
        S_TICK
    } t_state;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [ID_W-1:0]         timer_id;
        logic [FIELD_TIME_W-1:0] expire_time;
        logic [FIELD_TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] expired_id;
        logic            expired_flag;
        logic [1:0]      status;
        logic            last;
    } t_out_item;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== sv/stq_cell.sv =====
// One cell of the sorted row: holds a single timer entry and shifts with its neighbours.
module stq_cell import stq_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [ID_W-1:0]      i_new_id,
    input  logic [TIME_BITS-1:0] i_new_exp,
    input  logic                 i_left_valid,
    input  logic [ID_W-1:0]      i_left_id,
    input  logic [TIME_BITS-1:0] i_left_exp,
    input  logic                 i_left_gt,
    input  logic                 i_right_valid,
    input  logic [ID_W-1:0]      i_right_id,
    input  logic [TIME_BITS-1:0] i_right_exp,
    input  logic                 i_rem_sel,
    output logic                 o_valid,
    output logic [ID_W-1:0]      o_id,
    output logic [TIME_BITS-1:0] o_exp,
    output logic                 o_gt,
    output logic                 o_hit
);

    logic                 r_valid, n_valid;
    logic [ID_W-1:0]      r_id, n_id;
    logic [TIME_BITS-1:0] r_exp, n_exp;
    logic                 gt;

    // Empty cells count as later than anything, so the flags rise once along the row
    assign gt = !r_valid || (i_new_exp < r_exp);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_exp   = r_exp;
        if (i_ctl.ins && gt) begin
            if (i_left_gt) begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_exp   = i_left_exp;
            end else begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_exp   = i_new_exp;
            end
        end else if (i_ctl.rem && i_rem_sel) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_exp   = i_right_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_exp <= n_exp;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_exp   = r_exp;
    assign o_gt    = gt;
    assign o_hit   = r_valid && (r_id == i_new_id);

endmodule

// ===== sv/sorted_timer_queue_core.sv =====
// Sorted timer queue: a row of MAX_TIMERS cells kept in ascending expiry order, equal
// expiries in arrival order. Insert and delete act on the row once the result register
// is free, adjust (delete then re-place) removes in S_EXEC and re-places in S_PLACE,
// and a tick removes one expired timer from the head per cycle while the output is not
// stalled, up to 16 per tick, one result each. Each result waits in an output register,
// so a downstream stall holds the row; a new transaction is taken once the previous one
// has issued its final result.
module sorted_timer_queue_core import stq_pkg::*; #(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int EXT_W = TIME_BITS + FIELD_TIME_W;

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_exp;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [EXT_W-1:0]     in_exp_ext;
    logic [EXT_W-1:0]     in_now_ext;
    logic                 in_accept;
    logic                 slot_free;
    logic                 id_ok;
    logic                 act;
    logic                 head_due;
    logic                 next_due;
    logic                 tick_last;
    logic                 emit;
    t_out_item            emit_item;
    t_cell_ctl            ctl;
    logic                 pop;

    logic                 cv   [MAX_TIMERS];
    logic [ID_W-1:0]      cid  [MAX_TIMERS];
    logic [TIME_BITS-1:0] cexp [MAX_TIMERS];
    logic                 cgt  [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] hit;
    logic [MAX_TIMERS-1:0] rem_sel;

    assign in_exp_ext = {{TIME_BITS{1'b0}}, i_in_data.expire_time};
    assign in_now_ext = {{TIME_BITS{1'b0}}, i_in_data.now_time};
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    assign id_ok     = (32'(r_id) < MAX_TIMERS);
    assign act       = |hit;
    assign head_due  = cv[0] && (r_now >= cexp[0]);
    assign next_due  = cv[1] && (r_now >= cexp[1]);
    assign tick_last = !head_due || !next_due || (r_cnt == CNT_W'(RESULT_CAP - 1));

    // Cells at or behind the removed entry pull from their right neighbour
    always_comb begin
        rem_sel[0] = pop || hit[0];
        for (int k = 1; k < MAX_TIMERS; k++) begin
            rem_sel[k] = rem_sel[k-1] || hit[k];
        end
    end

    for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
        logic                 left_valid;
        logic [ID_W-1:0]      left_id;
        logic [TIME_BITS-1:0] left_exp;
        logic                 left_gt;
        logic                 right_valid;
        logic [ID_W-1:0]      right_id;
        logic [TIME_BITS-1:0] right_exp;

        if (g == 0) begin : g_first
            assign left_valid = 1'b0;
            assign left_id    = '0;
            assign left_exp   = '0;
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_valid = cv[g-1];
            assign left_id    = cid[g-1];
            assign left_exp   = cexp[g-1];
            assign left_gt    = cgt[g-1];
        end

        if (g == MAX_TIMERS - 1) begin : g_end
            assign right_valid = 1'b0;
            assign right_id    = '0;
            assign right_exp   = '0;
        end else begin : g_inner
            assign right_valid = cv[g+1];
            assign right_id    = cid[g+1];
            assign right_exp   = cexp[g+1];
        end

        stq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_id      (r_id),
            .i_new_exp     (r_exp),
            .i_left_valid  (left_valid),
            .i_left_id     (left_id),
            .i_left_exp    (left_exp),
            .i_left_gt     (left_gt),
            .i_right_valid (right_valid),
            .i_right_id    (right_id),
            .i_right_exp   (right_exp),
            .i_rem_sel     (rem_sel[g]),
            .o_valid       (cv[g]),
            .o_id          (cid[g]),
            .o_exp         (cexp[g]),
            .o_gt          (cgt[g]),
            .o_hit         (hit[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (t_req'(i_in_data.req_type) == REQ_TICK) ? S_TICK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = (r_req == REQ_ADJUST && act) ? S_PLACE : S_IDLE;
                end
            end
            S_PLACE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (slot_free && tick_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Row commands and results
    always_comb begin
        ctl       = '0;
        pop       = 1'b0;
        emit      = 1'b0;
        emit_item = '0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                if (slot_free) begin
                    case (r_req)
                        REQ_INSERT: begin
                            emit           = 1'b1;
                            emit_item.last = 1'b1;
                            if (!id_ok) begin
                                emit_item.status = ST_NOT_ACTIVE;
                            end else if (act) begin
                                emit_item.status = ST_ACTIVE;
                            end else begin
                                emit_item.status = ST_OK;
                                ctl.ins          = 1'b1;
                            end
                        end
                        REQ_ADJUST: begin
                            if (act) begin
                                ctl.rem = 1'b1;
                            end else begin
                                emit             = 1'b1;
                                emit_item.last   = 1'b1;
                                emit_item.status = ST_NOT_ACTIVE;
                            end
                        end
                        default: begin
                            emit           = 1'b1;
                            emit_item.last = 1'b1;
                            if (act) begin
                                ctl.rem          = 1'b1;
                                emit_item.status = ST_OK;
                            end else begin
                                emit_item.status = ST_NOT_ACTIVE;
                            end
                        end
                    endcase
                end
            end
            S_PLACE: begin
                if (slot_free) begin
                    ctl.ins          = 1'b1;
                    emit             = 1'b1;
                    emit_item.last   = 1'b1;
                    emit_item.status = ST_OK;
                end
            end
            S_TICK: begin
                if (slot_free) begin
                    emit           = 1'b1;
                    emit_item.last = tick_last;
                    if (head_due) begin
                        ctl.rem                = 1'b1;
                        pop                    = 1'b1;
                        emit_item.expired_id   = cid[0];
                        emit_item.expired_flag = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_cnt <= '0;
            end else if (pop) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= t_req'(i_in_data.req_type);
            r_id  <= i_in_data.timer_id;
            r_exp <= in_exp_ext[TIME_BITS-1:0];
            r_now <= in_now_ext[TIME_BITS-1:0];
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/sorted_timer_queue_core_tb.sv =====
// Testbench for the sorted timer queue core: ordering scoreboard and request drivers.
module sorted_timer_queue_core_tb;
    import stq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_TIMERS_DEF;

    // Shadow copy of the timer list; slots held in expiry order, front expires first
    class timer_order_tracker;
        logic [FIELD_TIME_W-1:0] expiry_of [SLOTS];
        bit                      live [SLOTS];
        logic [ID_W-1:0]         order_q [$];
        t_out_item               due_results [$];
        int                      fail_count;

        function new();
            fail_count = 0;
            foreach (live[s]) begin
                live[s] = 1'b0;
                expiry_of[s] = '0;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function logic [ID_W-1:0] pick_slot(bit want_live);
            logic [ID_W-1:0] cands [$];
            for (int s = 0; s < SLOTS; s++) begin
                if (live[s] == want_live) cands.push_back(ID_W'(s));
            end
            if (cands.size() == 0) return ID_W'($urandom_range(0, SLOTS - 1));
            return cands[$urandom_range(0, cands.size() - 1)];
        endfunction

        function void add_outcome(logic [ID_W-1:0] id, logic flag, t_status st, logic fin);
            t_out_item res;
            res.expired_id   = id;
            res.expired_flag = flag;
            res.status       = st;
            res.last         = fin;
            due_results.push_back(res);
        endfunction

        // goes after every entry whose expiry is not later
        function void place(logic [ID_W-1:0] id, logic [FIELD_TIME_W-1:0] expiry);
            int k;
            k = 0;
            while (k < order_q.size() && expiry >= expiry_of[order_q[k]]) k++;
            order_q.insert(k, id);
            expiry_of[id] = expiry;
            live[id] = 1'b1;
        endfunction

        function void unlink(logic [ID_W-1:0] id);
            for (int k = 0; k < order_q.size(); k++) begin
                if (order_q[k] == id) begin
                    order_q.delete(k);
                    break;
                end
            end
            live[id] = 1'b0;
        endfunction

        function void take_request(t_in_item req);
            logic [ID_W-1:0] id;
            int n;
            id = req.timer_id;
            n = 0;
            case (t_req'(req.req_type))
                REQ_INSERT: begin
                    if (live[id]) begin
                        add_outcome('0, 1'b0, ST_ACTIVE, 1'b1);
                    end else begin
                        place(id, req.expire_time);
                        add_outcome('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                REQ_ADJUST: begin
                    if (!live[id]) begin
                        add_outcome('0, 1'b0, ST_NOT_ACTIVE, 1'b1);
                    end else begin
                        unlink(id);
                        place(id, req.expire_time);
                        add_outcome('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                REQ_DELETE: begin
                    if (!live[id]) begin
                        add_outcome('0, 1'b0, ST_NOT_ACTIVE, 1'b1);
                    end else begin
                        unlink(id);
                        add_outcome('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                default: begin
                    while (order_q.size() > 0 && n < RESULT_CAP &&
                           req.now_time >= expiry_of[order_q[0]]) begin
                        add_outcome(order_q[0], 1'b1, ST_OK, 1'b0);
                        live[order_q[0]] = 1'b0;
                        void'(order_q.pop_front());
                        n++;
                    end
                    if (n == 0) add_outcome('0, 1'b0, ST_OK, 1'b1);
                    else due_results[due_results.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: id %0d flag %0d status %0d last %0d",
                       got.expired_id, got.expired_flag, got.status, got.last);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.expired_id !== want.expired_id) begin
                $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
                fail_count++;
            end
            if (got.expired_flag !== want.expired_flag) begin
                $error("expired_flag: expected %0d, got %0d", want.expired_flag,
                       got.expired_flag);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    timer_order_tracker      tracker = new();
    bit                      idle_on;
    int                      sink_hold_len;
    logic [FIELD_TIME_W-1:0] clock_now;

    sorted_timer_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_in_item make_request(t_req kind, logic [ID_W-1:0] id,
                                              logic [FIELD_TIME_W-1:0] expiry,
                                              logic [FIELD_TIME_W-1:0] now);
        t_in_item req;
        req.req_type    = kind;
        req.timer_id    = id;
        req.expire_time = expiry;
        req.now_time    = now;
        return req;
    endfunction

    // Mostly sensible sequences around a moving notion of time, with some noise
    function automatic t_in_item random_request();
        int       pick;
        t_in_item req;
        pick = $urandom_range(0, 99);
        req.timer_id    = ID_W'($urandom_range(0, SLOTS - 1));
        req.expire_time = $urandom;
        req.now_time    = $urandom;
        if ($urandom_range(0, 99) < 85) req.expire_time = clock_now + $urandom_range(0, 40);
        if (pick < 35) begin
            req.req_type = REQ_INSERT;
            if ($urandom_range(0, 9) < 8) req.timer_id = tracker.pick_slot(1'b0);
        end else if (pick < 55) begin
            req.req_type = REQ_ADJUST;
            if ($urandom_range(0, 9) < 8) req.timer_id = tracker.pick_slot(1'b1);
        end else if (pick < 70) begin
            req.req_type = REQ_DELETE;
            if ($urandom_range(0, 9) < 8) req.timer_id = tracker.pick_slot(1'b1);
        end else begin
            req.req_type = REQ_TICK;
            if ($urandom_range(0, 99) < 6) req.now_time = '1;
            else if ($urandom_range(0, 99) < 90) req.now_time = clock_now + $urandom_range(0, 20);
            clock_now = clock_now + $urandom_range(0, 12);
        end
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(t_in_item req);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_request(req);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_len != 0) begin
                hold_left = sink_hold_len;
                sink_hold_len = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_result(o_out_data);
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        idle_on = 1'b1;
        sink_hold_len = 0;
        clock_now = FIELD_TIME_W'($urandom_range(0, 1000));
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list tick, operations on idle slots
        send_request(make_request(REQ_TICK, 4'd9, '1, '0));
        send_request(make_request(REQ_ADJUST, 4'd3, 32'd50, '1));
        send_request(make_request(REQ_DELETE, 4'd3, '1, '1));
        // fill every slot; ids 1-3, 4-7, 8-11, 12-14 share expiries to test order
        for (int s = 0; s < SLOTS; s++) begin
            send_request(make_request(REQ_INSERT, ID_W'(s),
                                      s == 0 ? '0 : s == SLOTS - 1 ? '1 :
                                      FIELD_TIME_W'((s / 4) * 100 + 1), '0));
        end
        send_request(make_request(REQ_INSERT, 4'd5, 32'd7, '0));
        send_request(make_request(REQ_ADJUST, 4'd2, '1, '0));
        send_request(make_request(REQ_ADJUST, 4'd15, '0, '1));
        send_request(make_request(REQ_TICK, 4'd0, '0, '1));
        send_request(make_request(REQ_TICK, 4'd15, '1, '0));

        repeat (200) send_request(random_request());

        // receiver stalls for a long stretch while requests keep coming
        sink_hold_len = 80;
        repeat (60) send_request(random_request());

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);

        idle_on = 1'b0;
        repeat (187) send_request(random_request());
        i_in_valid <= 1'b0;

        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (tracker.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sorted_timer_queue_core.f =====
sv/stq_pkg.sv
sv/stq_cell.sv
sv/sorted_timer_queue_core.sv
dv/sorted_timer_queue_core_tb.sv
